/* rtl/core/skga_pkg.sv */
// shared constants, control types and codes of the sorted key group averager
package skga_pkg;

  localparam int unsigned INDEX_BITS_DEF = 10;
  localparam int unsigned COUNT_BITS_DEF = 16;
  localparam int unsigned VALUE_BITS     = 32;
  localparam int unsigned CFG_ADDR_BITS  = 3;

  // register indexes of the configuration port
  localparam logic [CFG_ADDR_BITS-1:0] CFG_H_LOWEST  = 3'd0;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_H_HIGHEST = 3'd1;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_K_LOWEST  = 3'd2;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_K_HIGHEST = 3'd3;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_L_LOWEST  = 3'd4;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_L_HIGHEST = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV_A,
    ST_EMIT_A,
    ST_START_B,
    ST_DIV_B,
    ST_EMIT_B
  } state_e;

  typedef struct packed {
    logic capture;
    logic absorb;
    logic fresh;
    logic div_start;
    logic load_out;
    logic final_flag;
    logic close;
  } cmd_t;

  typedef struct packed {
    logic change;
    logic last;
    logic div_done;
  } status_t;

endpackage

/* rtl/core/skga_if.sv */
// valid/ready channel interfaces: input items, results and configuration writes
interface skga_in_if #(
  parameter int unsigned IW = skga_pkg::INDEX_BITS_DEF
);
  logic                                  valid;
  logic                                  ready;
  logic signed [IW-1:0]                  h_index;
  logic signed [IW-1:0]                  k_index;
  logic signed [IW-1:0]                  l_index;
  logic signed [skga_pkg::VALUE_BITS-1:0] real_part;
  logic signed [skga_pkg::VALUE_BITS-1:0] imag_part;
  logic                                  stream_end;

  modport source (output valid, h_index, k_index, l_index, real_part, imag_part, stream_end,
                  input ready);
  modport sink   (input valid, h_index, k_index, l_index, real_part, imag_part, stream_end,
                  output ready);
endinterface

interface skga_out_if #(
  parameter int unsigned IW = skga_pkg::INDEX_BITS_DEF
);
  logic                                  valid;
  logic                                  ready;
  logic signed [IW-1:0]                  out_h;
  logic signed [IW-1:0]                  out_k;
  logic signed [IW-1:0]                  out_l;
  logic signed [skga_pkg::VALUE_BITS-1:0] mean_real;
  logic signed [skga_pkg::VALUE_BITS-1:0] mean_imag;
  logic                                  in_bounds;
  logic                                  final_result;

  modport source (output valid, out_h, out_k, out_l, mean_real, mean_imag, in_bounds,
                  final_result, input ready);
  modport sink   (input valid, out_h, out_k, out_l, mean_real, mean_imag, in_bounds,
                  final_result, output ready);
endinterface

interface skga_cfg_if #(
  parameter int unsigned IW = skga_pkg::INDEX_BITS_DEF
);
  logic                                valid;
  logic                                ready;
  logic [skga_pkg::CFG_ADDR_BITS-1:0]  index;
  logic signed [IW-1:0]                data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/skga_div.sv */
// radix-2 restoring divider, one quotient bit per cycle
module skga_div #(
  parameter int unsigned DW = 48,
  parameter int unsigned CW = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [CW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quot_o
);

  localparam int unsigned CNTW = $clog2(DW + 1);

  logic [DW-1:0]   quo_q, quo_d;
  logic [CW-1:0]   rem_q, rem_d;
  logic [CW-1:0]   dvs_q, dvs_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic            done_q, done_d;
  logic [CW:0]     shifted;
  logic [CW:0]     diff;

  assign shifted = {rem_q, quo_q[DW-1]};
  assign diff    = shifted - {1'b0, dvs_q};

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d = dividend_i;
      rem_d = '0;
      dvs_d = divisor_i;
      cnt_d = CNTW'(DW);
    end else if (cnt_q != '0) begin
      // borrow in the top bit means the divisor did not fit
      if (!diff[CW]) begin
        rem_d = diff[CW-1:0];
        quo_d = {quo_q[DW-2:0], 1'b1};
      end else begin
        rem_d = shifted[CW-1:0];
        quo_d = {quo_q[DW-2:0], 1'b0};
      end
      cnt_d  = cnt_q - CNTW'(1);
      done_d = (cnt_q == CNTW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

/* rtl/core/skga_datapath.sv */
// datapath: bounds registers, item latch, run accumulators, dividers, result register
module skga_datapath #(
  parameter int unsigned INDEX_BITS = skga_pkg::INDEX_BITS_DEF,
  parameter int unsigned COUNT_BITS = skga_pkg::COUNT_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [INDEX_BITS-1:0]              in_h_i,
  input  logic [INDEX_BITS-1:0]              in_k_i,
  input  logic [INDEX_BITS-1:0]              in_l_i,
  input  logic [skga_pkg::VALUE_BITS-1:0]    in_re_i,
  input  logic [skga_pkg::VALUE_BITS-1:0]    in_im_i,
  input  logic                               in_last_i,
  input  logic                               cfg_we_i,
  input  logic [skga_pkg::CFG_ADDR_BITS-1:0] cfg_idx_i,
  input  logic [INDEX_BITS-1:0]              cfg_data_i,
  input  skga_pkg::cmd_t                     cmd_i,
  output skga_pkg::status_t                  status_o,
  output logic [INDEX_BITS-1:0]              out_h_o,
  output logic [INDEX_BITS-1:0]              out_k_o,
  output logic [INDEX_BITS-1:0]              out_l_o,
  output logic [skga_pkg::VALUE_BITS-1:0]    mean_re_o,
  output logic [skga_pkg::VALUE_BITS-1:0]    mean_im_o,
  output logic                               in_bounds_o,
  output logic                               final_o
);

  localparam int unsigned IW = INDEX_BITS;
  localparam int unsigned VB = skga_pkg::VALUE_BITS;
  localparam int unsigned SB = VB + COUNT_BITS;
  localparam logic [IW-1:0] IDX_MAX = {1'b0, {(IW-1){1'b1}}};
  localparam logic [IW-1:0] IDX_MIN = {1'b1, {(IW-1){1'b0}}};

  // bounds registers
  logic [IW-1:0] h_lo_q, h_hi_q, k_lo_q, k_hi_q, l_lo_q, l_hi_q;

  // latched item
  logic [IW-1:0] it_h_q, it_k_q, it_l_q;
  logic [VB-1:0] it_re_q, it_im_q;
  logic          it_last_q;

  // open run
  logic                  open_q;
  logic [IW-1:0]         gh_q, gk_q, gl_q;
  logic [SB-1:0]         sre_q, sim_q;
  logic [COUNT_BITS-1:0] cnt_q;

  logic [SB-1:0]         base_re, base_im, new_re, new_im;
  logic [COUNT_BITS-1:0] base_cnt;
  logic                  can_add, load_key;
  logic [SB-1:0]         mag_re, mag_im, dvd_re, dvd_im, quo_re, quo_im;
  logic                  done_re, done_im;
  logic                  bounds_ok;

  function automatic logic [SB-1:0] sat_add(input logic [SB-1:0] s, input logic [VB-1:0] v);
    logic [SB:0] r;
    begin
      r = {s[SB-1], s} + {{(SB+1-VB){v[VB-1]}}, v};
      if (r[SB] != r[SB-1]) begin
        sat_add = r[SB] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
      end else begin
        sat_add = r[SB-1:0];
      end
    end
  endfunction

  // clamp the magnitude quotient to the 32-bit signed range and apply the sign
  function automatic logic [VB-1:0] clamp_mean(input logic neg, input logic [SB-1:0] q);
    logic [SB-1:0] lim;
    logic [SB-1:0] qc;
    begin
      lim = neg ? (SB'(1) << (VB - 1)) : ((SB'(1) << (VB - 1)) - SB'(1));
      qc  = (q > lim) ? lim : q;
      clamp_mean = neg ? (~qc[VB-1:0] + VB'(1)) : qc[VB-1:0];
    end
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_lo_q <= '0;
      h_hi_q <= IDX_MAX;
      k_lo_q <= IDX_MIN;
      k_hi_q <= IDX_MAX;
      l_lo_q <= IDX_MIN;
      l_hi_q <= IDX_MAX;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        skga_pkg::CFG_H_LOWEST:  h_lo_q <= cfg_data_i;
        skga_pkg::CFG_H_HIGHEST: h_hi_q <= cfg_data_i;
        skga_pkg::CFG_K_LOWEST:  k_lo_q <= cfg_data_i;
        skga_pkg::CFG_K_HIGHEST: k_hi_q <= cfg_data_i;
        skga_pkg::CFG_L_LOWEST:  l_lo_q <= cfg_data_i;
        skga_pkg::CFG_L_HIGHEST: l_hi_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      it_h_q    <= in_h_i;
      it_k_q    <= in_k_i;
      it_l_q    <= in_l_i;
      it_re_q   <= in_re_i;
      it_im_q   <= in_im_i;
      it_last_q <= in_last_i;
    end
  end

  // a fresh run starts from zero sums and count
  assign base_re  = cmd_i.fresh ? '0 : sre_q;
  assign base_im  = cmd_i.fresh ? '0 : sim_q;
  assign base_cnt = cmd_i.fresh ? '0 : cnt_q;
  assign can_add  = cmd_i.fresh || (cnt_q != '1);
  assign load_key = cmd_i.fresh || !open_q;
  assign new_re   = sat_add(base_re, it_re_q);
  assign new_im   = sat_add(base_im, it_im_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      gh_q   <= '0;
      gk_q   <= '0;
      gl_q   <= '0;
      sre_q  <= '0;
      sim_q  <= '0;
      cnt_q  <= '0;
    end else if (cmd_i.close) begin
      open_q <= 1'b0;
      gh_q   <= '0;
      gk_q   <= '0;
      gl_q   <= '0;
      sre_q  <= '0;
      sim_q  <= '0;
      cnt_q  <= '0;
    end else if (cmd_i.absorb) begin
      open_q <= 1'b1;
      if (load_key) begin
        gh_q <= it_h_q;
        gk_q <= it_k_q;
        gl_q <= it_l_q;
      end
      if (can_add) begin
        sre_q <= new_re;
        sim_q <= new_im;
        cnt_q <= base_cnt + COUNT_BITS'(1);
      end
    end
  end

  // rounded magnitude: (|sum| + count/2) / count
  assign mag_re = sre_q[SB-1] ? (~sre_q + SB'(1)) : sre_q;
  assign mag_im = sim_q[SB-1] ? (~sim_q + SB'(1)) : sim_q;
  assign dvd_re = mag_re + SB'(cnt_q >> 1);
  assign dvd_im = mag_im + SB'(cnt_q >> 1);

  skga_div #(.DW(SB), .CW(COUNT_BITS)) u_div_re (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dvd_re),
    .divisor_i  (cnt_q),
    .done_o     (done_re),
    .quot_o     (quo_re)
  );

  skga_div #(.DW(SB), .CW(COUNT_BITS)) u_div_im (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dvd_im),
    .divisor_i  (cnt_q),
    .done_o     (done_im),
    .quot_o     (quo_im)
  );

  // inverted bounds never match since both compares cannot hold
  assign bounds_ok = ($signed(gh_q) >= $signed(h_lo_q)) && ($signed(gh_q) <= $signed(h_hi_q)) &&
                     ($signed(gk_q) >= $signed(k_lo_q)) && ($signed(gk_q) <= $signed(k_hi_q)) &&
                     ($signed(gl_q) >= $signed(l_lo_q)) && ($signed(gl_q) <= $signed(l_hi_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_h_o     <= gh_q;
      out_k_o     <= gk_q;
      out_l_o     <= gl_q;
      mean_re_o   <= clamp_mean(sre_q[SB-1], quo_re);
      mean_im_o   <= clamp_mean(sim_q[SB-1], quo_im);
      in_bounds_o <= bounds_ok;
      final_o     <= cmd_i.final_flag;
    end
  end

  assign status_o.change   = open_q && ((it_h_q != gh_q) || (it_k_q != gk_q) ||
                                        (it_l_q != gl_q));
  assign status_o.last     = it_last_q;
  assign status_o.div_done = done_re;

`ifndef ASSERT_OFF
  a_div_lanes_agree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_re == done_im)
    else $error("real and imaginary dividers out of step");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_start |-> (open_q && (cnt_q != '0)))
    else $error("division started on an empty run");

  a_emit_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> open_q)
    else $error("result loaded with no open run");
`endif

endmodule

/* rtl/core/skga_ctrl.sv */
// controller: sequences capture, key check, division and result hand-off
module skga_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  skga_pkg::status_t status_i,
  output skga_pkg::cmd_t    cmd_o
);

  skga_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;

  // result register can take a new result this cycle
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      skga_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = skga_pkg::ST_CHECK;
      end
      skga_pkg::ST_CHECK: begin
        if (status_i.change)    state_d = skga_pkg::ST_DIV_A;
        else if (status_i.last) state_d = skga_pkg::ST_START_B;
        else                    state_d = skga_pkg::ST_IDLE;
      end
      skga_pkg::ST_DIV_A: begin
        if (status_i.div_done) state_d = skga_pkg::ST_EMIT_A;
      end
      skga_pkg::ST_EMIT_A: begin
        if (out_free) state_d = status_i.last ? skga_pkg::ST_START_B : skga_pkg::ST_IDLE;
      end
      skga_pkg::ST_START_B: begin
        state_d = skga_pkg::ST_DIV_B;
      end
      skga_pkg::ST_DIV_B: begin
        if (status_i.div_done) state_d = skga_pkg::ST_EMIT_B;
      end
      skga_pkg::ST_EMIT_B: begin
        if (out_free) state_d = skga_pkg::ST_IDLE;
      end
      default: state_d = skga_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      skga_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      skga_pkg::ST_CHECK: begin
        if (status_i.change) cmd_o.div_start = 1'b1;
        else                 cmd_o.absorb    = 1'b1;
      end
      skga_pkg::ST_EMIT_A: begin
        if (out_free) begin
          cmd_o.load_out   = 1'b1;
          cmd_o.final_flag = !status_i.last;
          cmd_o.absorb     = 1'b1;
          cmd_o.fresh      = 1'b1;
        end
      end
      skga_pkg::ST_START_B: begin
        cmd_o.div_start = 1'b1;
      end
      skga_pkg::ST_EMIT_B: begin
        if (out_free) begin
          cmd_o.load_out   = 1'b1;
          cmd_o.final_flag = 1'b1;
          cmd_o.close      = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_d = cmd_o.load_out ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= skga_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef ASSERT_OFF
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (!out_valid_q || out_ready_i))
    else $error("pending result overwritten");

  a_div_follows_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |=> (state_q == skga_pkg::ST_DIV_A || state_q == skga_pkg::ST_DIV_B))
    else $error("division started outside the division sequence");

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_i.div_done |-> (state_q == skga_pkg::ST_DIV_A || state_q == skga_pkg::ST_DIV_B))
    else $error("division finished while not waiting for it");
`endif

endmodule

/* rtl/core/sorted_key_group_average.sv */
// top level of the sorted key group averager
//
//  channel | dir | handshake        | payload
//  --------+-----+------------------+------------------------------------------------
//  in_i    | in  | valid / ready    | h/k/l_index, real_part, imag_part, stream_end
//  out_o   | out | valid / ready    | out_h/k/l, mean_real, mean_imag, in_bounds, final_result
//  cfg_i   | in  | valid / ready=1  | index (register 0..5), data
//
//  one item at a time: an item that closes no run passes through idle and the key check
//  a key change and a stream end each wait on the bit-serial dividers (real and
//  imaginary quotients run side by side, one bit per cycle)
//  an item that both changes the key and ends the stream gives two results:
//  first the mean of the closed run, then the mean of the run holding that item
//  reset clears the bounds to their defaults and closes any open run
//  a result waiting in the output register only stalls the block when the next one is ready
module sorted_key_group_average #(
  parameter int unsigned INDEX_BITS = skga_pkg::INDEX_BITS_DEF,
  parameter int unsigned COUNT_BITS = skga_pkg::COUNT_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  skga_in_if.sink     in_i,
  skga_out_if.source  out_o,
  skga_cfg_if.sink    cfg_i
);

  skga_pkg::cmd_t    cmd;
  skga_pkg::status_t status;

  logic [INDEX_BITS-1:0]           out_h, out_k, out_l;
  logic [skga_pkg::VALUE_BITS-1:0] mean_re, mean_im;
  logic                            in_bounds, final_flag;

  // configuration writes are always taken; the user must write only while the block is quiet
  assign cfg_i.ready = 1'b1;

  // sequencing: capture, key check, divisions, result hand-off
  skga_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // accumulators, bounds check and the two dividers
  skga_datapath #(
    .INDEX_BITS (INDEX_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_h_i      (in_i.h_index),
    .in_k_i      (in_i.k_index),
    .in_l_i      (in_i.l_index),
    .in_re_i     (in_i.real_part),
    .in_im_i     (in_i.imag_part),
    .in_last_i   (in_i.stream_end),
    .cfg_we_i    (cfg_i.valid),
    .cfg_idx_i   (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_h_o     (out_h),
    .out_k_o     (out_k),
    .out_l_o     (out_l),
    .mean_re_o   (mean_re),
    .mean_im_o   (mean_im),
    .in_bounds_o (in_bounds),
    .final_o     (final_flag)
  );

  assign out_o.out_h        = out_h;
  assign out_o.out_k        = out_k;
  assign out_o.out_l        = out_l;
  assign out_o.mean_real    = mean_re;
  assign out_o.mean_imag    = mean_im;
  assign out_o.in_bounds    = in_bounds;
  assign out_o.final_result = final_flag;

endmodule

/* tb/tb_sorted_key_group_average.sv */
`timescale 1ns / 1ps
// self-checking testbench of the sorted key group averager with its own run-mean predictor
module tb_sorted_key_group_average;

  localparam int unsigned IW = skga_pkg::INDEX_BITS_DEF;
  localparam int unsigned CW = skga_pkg::COUNT_BITS_DEF;
  localparam int unsigned VW = skga_pkg::VALUE_BITS;

  // indexes past the last bound register, the block drops writes to them
  localparam logic [skga_pkg::CFG_ADDR_BITS-1:0] CFG_SPARE_FIRST = 3'd6;
  localparam logic [skga_pkg::CFG_ADDR_BITS-1:0] CFG_SPARE_LAST  = 3'd7;

  // one result is about one pass of the bit-serial dividers, two may come back to back
  localparam int RESULT_CYCLES  = VW + CW + 4;
  localparam int DRAIN_CYCLES   = 2 * RESULT_CYCLES + 16;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 5000;

  localparam longint          SUM_MAX    = (longint'(1) <<< (VW + CW - 1)) - 1;
  localparam longint          SUM_MIN    = -SUM_MAX - 1;
  localparam longint unsigned COUNT_FULL = (64'd1 << CW) - 1;

  typedef logic signed [IW-1:0] key_t;
  typedef logic signed [VW-1:0] value_t;

  localparam key_t   IDX_MIN = {1'b1, {(IW-1){1'b0}}};
  localparam key_t   IDX_MAX = {1'b0, {(IW-1){1'b1}}};
  localparam value_t VAL_MIN = {1'b1, {(VW-1){1'b0}}};
  localparam value_t VAL_MAX = {1'b0, {(VW-1){1'b1}}};

  typedef struct {
    key_t   h;
    key_t   k;
    key_t   l;
    value_t re;
    value_t im;
    logic   last;
  } sample_t;

  typedef struct {
    key_t   h;
    key_t   k;
    key_t   l;
    value_t mean_re;
    value_t mean_im;
    logic   in_bounds;
    logic   final_result;
  } group_mean_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #5 clk_i = ~clk_i;

  skga_in_if  in_if  ();
  skga_out_if out_if ();
  skga_cfg_if cfg_if ();

  sorted_key_group_average dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // predictor state: bound registers and the open run
  key_t            bound_reg [6];
  logic            run_open;
  key_t            run_h;
  key_t            run_k;
  key_t            run_l;
  longint          run_sum_re;
  longint          run_sum_im;
  longint unsigned run_count;

  group_mean_t expected_groups [$];
  int          mismatch_count = 0;

  // handshake pacing
  bit   idle_on      = 1'b1;
  logic sink_hold    = 1'b0;
  int   sink_gap     = 0;
  int   quiet_cycles = 0;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic void close_run();
    run_open   = 1'b0;
    run_h      = '0;
    run_k      = '0;
    run_l      = '0;
    run_sum_re = 0;
    run_sum_im = 0;
    run_count  = 0;
  endfunction

  function automatic void reset_model();
    bound_reg[skga_pkg::CFG_H_LOWEST]  = '0;
    bound_reg[skga_pkg::CFG_H_HIGHEST] = IDX_MAX;
    bound_reg[skga_pkg::CFG_K_LOWEST]  = IDX_MIN;
    bound_reg[skga_pkg::CFG_K_HIGHEST] = IDX_MAX;
    bound_reg[skga_pkg::CFG_L_LOWEST]  = IDX_MIN;
    bound_reg[skga_pkg::CFG_L_HIGHEST] = IDX_MAX;
    close_run();
  endfunction

  // sums clamp at the limits of the wide accumulator
  function automatic longint sat_add(input longint acc, input value_t v);
    longint r;
    r = acc + v;
    if (r > SUM_MAX) return SUM_MAX;
    if (r < SUM_MIN) return SUM_MIN;
    return r;
  endfunction

  // sum / count rounded to nearest, halves away from zero, clamped to the value width
  function automatic value_t mean_of(input longint sum, input longint unsigned cnt);
    longint unsigned mag;
    longint unsigned q;
    if (cnt == 0) return '0;
    mag = (sum < 0) ? -sum : sum;
    q   = (mag + cnt / 2) / cnt;
    if (sum < 0) begin
      if (q > 64'h8000_0000) q = 64'h8000_0000;
      return value_t'(64'd0 - q);
    end
    if (q > 64'h7fff_ffff) q = 64'h7fff_ffff;
    return value_t'(q);
  endfunction

  // an inverted pair (lowest above highest) matches nothing
  function automatic logic key_inside(input key_t v, input key_t lo, input key_t hi);
    return (v >= lo) && (v <= hi);
  endfunction

  function automatic group_mean_t current_group();
    group_mean_t g;
    g.h            = run_h;
    g.k            = run_k;
    g.l            = run_l;
    g.mean_re      = mean_of(run_sum_re, run_count);
    g.mean_im      = mean_of(run_sum_im, run_count);
    g.in_bounds    = key_inside(run_h, bound_reg[skga_pkg::CFG_H_LOWEST],
                                bound_reg[skga_pkg::CFG_H_HIGHEST]) &&
                     key_inside(run_k, bound_reg[skga_pkg::CFG_K_LOWEST],
                                bound_reg[skga_pkg::CFG_K_HIGHEST]) &&
                     key_inside(run_l, bound_reg[skga_pkg::CFG_L_LOWEST],
                                bound_reg[skga_pkg::CFG_L_HIGHEST]);
    g.final_result = 1'b0;
    return g;
  endfunction

  // appends one predicted result to the tail of the expected queue
  function automatic void add_expected(input group_mean_t g);
    expected_groups.insert(expected_groups.size(), g);
  endfunction

  // one accepted sample: a key change closes the open run first, stream end flushes
  // the run holding this sample; the last result of the sample carries final_result
  function automatic void predict_group_results(input sample_t s);
    group_mean_t res [2];
    int          n;
    n = 0;
    if (run_open && (s.h != run_h || s.k != run_k || s.l != run_l)) begin
      res[n] = current_group();
      n++;
      close_run();
    end
    if (!run_open) begin
      run_open = 1'b1;
      run_h    = s.h;
      run_k    = s.k;
      run_l    = s.l;
    end
    // a full count freezes the run: further samples of the same key are dropped
    if (run_count < COUNT_FULL) begin
      run_count++;
      run_sum_re = sat_add(run_sum_re, s.re);
      run_sum_im = sat_add(run_sum_im, s.im);
    end
    if (s.last) begin
      res[n] = current_group();
      n++;
      close_run();
    end
    for (int i = 0; i < n; i++) begin
      res[i].final_result = (i == n - 1);
      add_expected(res[i]);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // result checking and receiver pacing
  // ---------------------------------------------------------------------------

  function automatic void check_field(input string name, input logic signed [63:0] want,
                                      input logic signed [63:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // outputs are sampled at the edge, before the block's own updates land
  always @(posedge clk_i) begin
    group_mean_t want;
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (expected_groups.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result, expected none, actual key %0d %0d %0d", $time,
                 out_if.out_h, out_if.out_k, out_if.out_l);
      end else begin
        want = expected_groups.pop_front();
        check_field("out_h", want.h, out_if.out_h);
        check_field("out_k", want.k, out_if.out_k);
        check_field("out_l", want.l, out_if.out_l);
        check_field("mean_real", want.mean_re, out_if.mean_real);
        check_field("mean_imag", want.mean_im, out_if.mean_imag);
        check_field("in_bounds", want.in_bounds, out_if.in_bounds);
        check_field("final_result", want.final_result, out_if.final_result);
      end
    end
  end

  // ready drops in short random bursts, or for as long as the long hold-off lasts
  always @(posedge clk_i) begin
    if (sink_hold) begin
      out_if.ready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap--;
      out_if.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      sink_gap = $urandom_range(1, 7) - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // watchdog: cycles in which no transaction happens on any channel
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // valid stays high from one sample to the next unless a gap is drawn
  task automatic send_sample(input sample_t s);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.h_index    <= s.h;
    in_if.k_index    <= s.k;
    in_if.l_index    <= s.l;
    in_if.real_part  <= s.re;
    in_if.imag_part  <= s.im;
    in_if.stream_end <= s.last;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    predict_group_results(s);
  endtask

  // sender stops until every expected result has come back
  task automatic pause_until_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (expected_groups.size() != 0);
  endtask

  // as above, then let a sample that gave no result finish inside the block
  task automatic wait_drained();
    pause_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // writes all six bounds in index order, then one write to a spare index
  task automatic set_bounds(input key_t hl, input key_t hh, input key_t kl, input key_t kh,
                            input key_t ll, input key_t lh);
    key_t                               vals [6];
    logic [skga_pkg::CFG_ADDR_BITS-1:0] regs [6];
    logic [skga_pkg::CFG_ADDR_BITS-1:0] wr_idx;
    key_t                               wr_data;
    vals = '{hl, hh, kl, kh, ll, lh};
    regs = '{skga_pkg::CFG_H_LOWEST, skga_pkg::CFG_H_HIGHEST, skga_pkg::CFG_K_LOWEST,
             skga_pkg::CFG_K_HIGHEST, skga_pkg::CFG_L_LOWEST, skga_pkg::CFG_L_HIGHEST};
    for (int i = 0; i < 7; i++) begin
      if (i < 6) begin
        wr_idx  = regs[i];
        wr_data = vals[i];
      end else begin
        wr_idx  = skga_pkg::CFG_ADDR_BITS'($urandom_range(CFG_SPARE_FIRST, CFG_SPARE_LAST));
        wr_data = key_t'($urandom);
      end
      cfg_if.valid <= 1'b1;
      cfg_if.index <= wr_idx;
      cfg_if.data  <= wr_data;
      do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
      if (wr_idx <= skga_pkg::CFG_L_HIGHEST) bound_reg[wr_idx] = wr_data;
    end
    cfg_if.valid <= 1'b0;
  endtask

  function automatic sample_t make_sample(input key_t h, input key_t k, input key_t l,
                                          input value_t re, input value_t im, input logic last);
    sample_t s;
    s.h    = h;
    s.k    = k;
    s.l    = l;
    s.re   = re;
    s.im   = im;
    s.last = last;
    return s;
  endfunction

  // coordinates on and just past the current bounds, wrapping at the index width, or random
  function automatic key_t pick_coord(input key_t lo, input key_t hi);
    case ($urandom_range(0, 4))
      0:       return key_t'(lo - 1);
      1:       return lo;
      2:       return hi;
      3:       return key_t'(hi + 1);
      default: return key_t'($urandom);
    endcase
  endfunction

  function automatic value_t random_value();
    case ($urandom_range(0, 5))
      0:       return VAL_MAX;
      1:       return VAL_MIN;
      2, 3:    return value_t'(int'($urandom_range(0, 8191)) - 4096);
      default: return value_t'($urandom);
    endcase
  endfunction

  // runs of 1 to 6 samples with one key each; keys random, near the bounds, or a key
  // from two runs back (out of order); stream end now and then mid-run or at a run's
  // end, and always on the final sample so the last run is flushed
  task automatic send_random_runs(input int n_items);
    key_t    cur   [3];
    key_t    prev  [3];
    key_t    older [3];
    sample_t s;
    int      sent;
    int      len;
    int      pick;
    sent  = 0;
    prev  = '{'0, '0, '0};
    older = '{'0, '0, '0};
    while (sent < n_items) begin
      pick = $urandom_range(0, 9);
      for (int a = 0; a < 3; a++) begin
        if (pick < 4)
          cur[a] = key_t'($urandom);
        else if (pick < 8)
          cur[a] = pick_coord(bound_reg[skga_pkg::CFG_H_LOWEST + 2 * a],
                              bound_reg[skga_pkg::CFG_H_HIGHEST + 2 * a]);
        else
          cur[a] = older[a];
      end
      len = $urandom_range(1, 6);
      if (len > n_items - sent) len = n_items - sent;
      for (int j = 0; j < len; j++) begin
        s = make_sample(cur[0], cur[1], cur[2], random_value(), random_value(), 1'b0);
        s.last = ($urandom_range(0, 29) == 0) || (sent == n_items - 1) ||
                 (j == len - 1 && $urandom_range(0, 7) == 0);
        send_sample(s);
        sent++;
      end
      older = prev;
      prev  = cur;
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset bounds (h from 0 up), value extremes, rounding of halves, key change,
  // stream end, both at once, a key coming back out of order, out of bounds keys
  task automatic test_directed_runs();
    send_sample(make_sample('0, IDX_MIN, IDX_MIN, VAL_MAX, VAL_MIN, 1'b0));
    send_sample(make_sample('0, IDX_MIN, IDX_MIN, VAL_MAX, VAL_MIN, 1'b0));
    send_sample(make_sample(IDX_MAX, IDX_MAX, IDX_MAX, 32'sd1, -32'sd1, 1'b0));
    send_sample(make_sample(IDX_MAX, IDX_MAX, IDX_MAX, '0, '0, 1'b0));
    send_sample(make_sample(-10'sd1, '0, '0, 32'sd1, -32'sd2, 1'b0));
    send_sample(make_sample(-10'sd1, '0, '0, '0, '0, 1'b0));
    send_sample(make_sample(-10'sd1, '0, '0, '0, '0, 1'b1));
    send_sample(make_sample(IDX_MIN, 10'sd5, 10'sd5, 32'sh0001_8000, -32'sh0001_8000, 1'b1));
    send_sample(make_sample(10'sd100, '0, '0, 32'sd3, 32'sd3, 1'b0));
    send_sample(make_sample(10'sd101, '0, '0, 32'sd5, -32'sd5, 1'b1));
    send_sample(make_sample(10'sd100, '0, '0, 32'sd7, 32'sd7, 1'b0));
    send_sample(make_sample(10'sd101, '0, '0, 32'sd9, 32'sd9, 1'b0));
    send_sample(make_sample(10'sd100, '0, '0, 32'sd11, -32'sd11, 1'b1));
    send_sample(make_sample('0, '0, '0, VAL_MIN, VAL_MIN, 1'b0));
    send_sample(make_sample('0, '0, '0, VAL_MIN, VAL_MAX, 1'b0));
    send_sample(make_sample('0, '0, '0, VAL_MIN, VAL_MIN, 1'b1));
    send_sample(make_sample(10'sd5, IDX_MAX, IDX_MIN, 32'sd2, -32'sd2, 1'b0));
    send_sample(make_sample(10'sd5, IDX_MAX, IDX_MIN, -32'sd1, 32'sd1, 1'b1));
    wait_drained();
  endtask

  // full range, inverted on every axis, a single point, then random bounds
  task automatic test_bound_settings();
    set_bounds(IDX_MIN, IDX_MAX, IDX_MIN, IDX_MAX, IDX_MIN, IDX_MAX);
    send_random_runs(12);
    wait_drained();
    set_bounds(IDX_MAX, IDX_MIN, IDX_MAX, IDX_MIN, IDX_MAX, IDX_MIN);
    send_random_runs(12);
    wait_drained();
    begin
      key_t ph;
      key_t pk;
      key_t pl;
      ph = key_t'($urandom);
      pk = key_t'($urandom);
      pl = key_t'($urandom);
      set_bounds(ph, ph, pk, pk, pl, pl);
    end
    send_random_runs(12);
    wait_drained();
    repeat (3) begin
      set_bounds(key_t'($urandom), key_t'($urandom), key_t'($urandom),
                 key_t'($urandom), key_t'($urandom), key_t'($urandom));
      send_random_runs(12);
      wait_drained();
    end
  endtask

  // receiver holds off long enough for the block to fill and stall its input
  task automatic test_result_backpressure();
    fork
      begin
        sink_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        sink_hold <= 1'b0;
      end
    join_none
    send_random_runs(40);
    wait_drained();
  endtask

  // long random stream in three phases with new bounds between them; the sender
  // pauses once mid-stream until all results are in; the last phase runs without gaps
  task automatic test_random_stream();
    set_bounds(key_t'($urandom), key_t'($urandom), IDX_MIN, IDX_MAX,
               key_t'($urandom), key_t'($urandom));
    send_random_runs(100);
    pause_until_drained();
    send_random_runs(100);
    wait_drained();
    set_bounds(key_t'($urandom), key_t'($urandom), key_t'($urandom),
               key_t'($urandom), key_t'($urandom), key_t'($urandom));
    send_random_runs(150);
    wait_drained();
    idle_on = 1'b0;
    set_bounds(IDX_MIN, IDX_MIN, IDX_MAX, IDX_MAX, IDX_MIN, IDX_MAX);
    send_random_runs(150);
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    in_if.valid      = 1'b0;
    in_if.h_index    = '0;
    in_if.k_index    = '0;
    in_if.l_index    = '0;
    in_if.real_part  = '0;
    in_if.imag_part  = '0;
    in_if.stream_end = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = '0;
    cfg_if.data      = '0;
    reset_model();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_runs();
    test_bound_settings();
    test_result_backpressure();
    test_random_stream();

    if (mismatch_count == 0 && expected_groups.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* sorted_key_group_average.f */
rtl/core/skga_pkg.sv
rtl/core/skga_if.sv
rtl/core/skga_div.sv
rtl/core/skga_datapath.sv
rtl/core/skga_ctrl.sv
rtl/core/sorted_key_group_average.sv
tb/tb_sorted_key_group_average.sv
